>>> rtl/hbkc_pkg.sv
// ----------------------------------------------------------------------------
// hbkc_pkg
// Types and constants shared by the hash bucket key compare block.
// ----------------------------------------------------------------------------
package hbkc_pkg;

   // Field widths of the request and response items
   localparam int unsigned BIN_SLOTS   = 4;
   localparam int unsigned OP_W        = 2;
   localparam int unsigned LEN_W       = 8;
   localparam int unsigned RQOP_W      = 4;
   localparam int unsigned SLICE_W     = 64;

   // Request op codes
   localparam logic [OP_W-1:0] OP_META = 2'd0;
   localparam logic [OP_W-1:0] OP_HEAD = 2'd1;
   localparam logic [OP_W-1:0] OP_KEY  = 2'd2;

   // Operation that streams the key without reading a header
   localparam logic [RQOP_W-1:0] STREAM_OP = 4'd8;

   // Bytes retired by each upper half (one 128-bit key word)
   localparam logic [LEN_W-1:0] BYTES_PER_WORD = 8'd16;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEAD,
      PH_COMPARE,
      PH_STREAM
   } phase_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [LEN_W-1:0]   key_length;
      logic [RQOP_W-1:0]  request_op;
      logic [SLICE_W-1:0] key_slice;
      logic [SLICE_W-1:0] bin0_slice;
      logic [SLICE_W-1:0] bin1_slice;
      logic [SLICE_W-1:0] bin2_slice;
      logic [SLICE_W-1:0] bin3_slice;
      logic               upper_half;
   } req_payload_type;

   typedef struct packed {
      logic [BIN_SLOTS-1:0] free_mask;
      logic [BIN_SLOTS-1:0] match_mask;
      logic [RQOP_W-1:0]    request_op_out;
      logic [LEN_W-1:0]     key_length_out;
   } rsp_payload_type;

   // Per-bin results of one request item
   typedef struct packed {
      logic [BIN_SLOTS-1:0] empty;    // header length byte is zero
      logic [BIN_SLOTS-1:0] len_hit;  // header length byte equals the key length
      logic [BIN_SLOTS-1:0] differ;   // key half differs from the bin half
   } bin_hits_type;

endpackage

>>> rtl/hbkc_if.sv
// ----------------------------------------------------------------------------
// hbkc_req_if / hbkc_rsp_if
// Valid/ready channels for the requests and the status responses.
// ----------------------------------------------------------------------------
interface hbkc_req_if
   import hbkc_pkg::*;
   ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface hbkc_rsp_if
   import hbkc_pkg::*;
   ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/hbkc_bin_cmp.sv
// ----------------------------------------------------------------------------
// hbkc_bin_cmp
// Per-bin header length checks and key half comparisons for one request.
// ----------------------------------------------------------------------------
module hbkc_bin_cmp
   import hbkc_pkg::*;
#(
   parameter int unsigned BINS = 4
) (
   input  req_payload_type  payload,
   input  logic [LEN_W-1:0] saved_length,
   output bin_hits_type     hits
);

   logic [SLICE_W-1:0] slices [BIN_SLOTS];

   always_comb begin
      slices[0] = payload.bin0_slice;
      slices[1] = payload.bin1_slice;
      slices[2] = payload.bin2_slice;
      slices[3] = payload.bin3_slice;
   end

   always_comb begin
      hits = '0;
      for (int i = 0; i < BIN_SLOTS; i++) begin
         if (i < BINS) begin
            hits.empty[i]   = (slices[i][LEN_W-1:0] == '0);
            hits.len_hit[i] = (slices[i][LEN_W-1:0] == saved_length);
            hits.differ[i]  = (slices[i] != payload.key_slice);
         end
      end
   end

endmodule

>>> rtl/hash_bucket_key_compare.sv
// ----------------------------------------------------------------------------
// hash_bucket_key_compare
// Checks a request key against the stored keys of one hash bucket.
// ----------------------------------------------------------------------------
// Each request is handled combinationally: the bin checks and the length count
// run between the request port and the state and response registers, so a new
// request can be accepted every cycle while no response is stalled. A request
// starts with metadata (op 0), then a bucket header (op 1) unless the operation
// is the stream-only code 8, then key halves (op 2). After the key half that ends
// the key, one status response appears in the next cycle. Requests that do not
// fit the current phase are accepted and dropped. The request side stalls only
// while a response is held and not taken.
module hash_bucket_key_compare
   import hbkc_pkg::*;
#(
   parameter int unsigned BINS = 4
) (
   input  logic        clock,
   input  logic        reset,
   hbkc_req_if.sink    req,
   hbkc_rsp_if.source  rsp
);

   phase_type            phase_ff, phase_in;
   logic [LEN_W-1:0]     remaining_ff, remaining_in;
   logic [RQOP_W-1:0]    saved_op_ff, saved_op_in;
   logic [LEN_W-1:0]     saved_length_ff, saved_length_in;
   logic [BIN_SLOTS-1:0] free_flags_ff, free_flags_in;
   logic [BIN_SLOTS-1:0] match_flags_ff, match_flags_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_payload_ff, rsp_payload_in;

   bin_hits_type         hits;
   logic                 req_fire;
   logic                 emit;
   logic [LEN_W-1:0]     remaining_dec;

   hbkc_bin_cmp #(
      .BINS (BINS)
   ) u_bin_cmp (
      .payload      (req.payload),
      .saved_length (saved_length_ff),
      .hits         (hits)
   );

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;

   assign remaining_dec = (remaining_ff > BYTES_PER_WORD) ?
                          remaining_ff - BYTES_PER_WORD : '0;

   always_comb begin
      phase_in        = phase_ff;
      remaining_in    = remaining_ff;
      saved_op_in     = saved_op_ff;
      saved_length_in = saved_length_ff;
      free_flags_in   = free_flags_ff;
      match_flags_in  = match_flags_ff;
      emit            = 1'b0;

      if (req_fire) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (req.payload.op == OP_META) begin
                  saved_length_in = req.payload.key_length;
                  saved_op_in     = req.payload.request_op;
                  remaining_in    = req.payload.key_length;
                  free_flags_in   = '0;
                  match_flags_in  = '0;
                  phase_in = (req.payload.request_op == STREAM_OP) ? PH_STREAM : PH_HEAD;
               end
            end
            PH_HEAD: begin
               if (req.payload.op == OP_HEAD) begin
                  free_flags_in  = free_flags_ff | hits.empty;
                  match_flags_in = match_flags_ff | (hits.len_hit & ~hits.empty);
                  phase_in       = PH_COMPARE;
               end
            end
            PH_COMPARE, PH_STREAM: begin
               if (req.payload.op == OP_KEY) begin
                  if (phase_ff == PH_COMPARE) begin
                     match_flags_in = match_flags_ff & ~hits.differ;
                  end
                  // only the upper half retires a word of the key
                  if (req.payload.upper_half) begin
                     remaining_in = remaining_dec;
                     if (remaining_dec == '0) begin
                        emit     = 1'b1;
                        phase_in = PH_IDLE;
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      rsp_payload_in.free_mask      = free_flags_in;
      rsp_payload_in.match_mask     = match_flags_in;
      rsp_payload_in.request_op_out = saved_op_ff;
      rsp_payload_in.key_length_out = saved_length_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         remaining_ff    <= '0;
         saved_op_ff     <= '0;
         saved_length_ff <= '0;
         free_flags_ff   <= '0;
         match_flags_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         remaining_ff    <= remaining_in;
         saved_op_ff     <= saved_op_in;
         saved_length_ff <= saved_length_in;
         free_flags_ff   <= free_flags_in;
         match_flags_ff  <= match_flags_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // hold the response payload until the next one is emitted
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_payload_ff;

   a_emit_goes_idle: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff && phase_ff == PH_IDLE)
      else $error("response emitted without returning to idle");

   a_stream_op: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_STREAM |-> saved_op_ff == STREAM_OP)
      else $error("stream phase with a non-stream operation");

   a_free_match_disjoint: assert property (@(posedge clock) disable iff (reset)
      (free_flags_ff & match_flags_ff) == '0)
      else $error("bin marked both free and matching");

   a_unused_bins_clear: assert property (@(posedge clock) disable iff (reset)
      ((free_flags_ff | match_flags_ff) >> BINS) == '0)
      else $error("flag set for a bin beyond the bucket size");

   a_stall_on_held_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !req.ready)
      else $error("request taken while a response is stalled");

endmodule
